// ===== hw/rtl/frtc_pkg.sv =====
// frtc_pkg: codes, constants and shared types of the frame request timestamp controller
// used by the tick converter and the top level; depends on nothing

package frtc_pkg;

  // 100 ns units per second, walked bit by bit by the converter's multiply steps
  localparam int unsigned HNS_W = 24;
  localparam logic [HNS_W-1:0] HNS_PER_SEC = 24'd10000000;

  // restoring division steps over a 65-bit dividend
  localparam int unsigned DIV_STEPS = 65;

  // event codes
  localparam logic [2:0] MODE_SET_STATE = 3'd0;
  localparam logic [2:0] MODE_START     = 3'd1;
  localparam logic [2:0] MODE_STOP      = 3'd2;
  localparam logic [2:0] MODE_SHUTDOWN  = 3'd3;
  localparam logic [2:0] MODE_REQUEST   = 3'd4;
  localparam logic [2:0] MODE_FRAME     = 3'd5;
  localparam logic [2:0] MODE_TICK      = 3'd6;

  // stream states, also the target codes of set state
  localparam logic [1:0] STRM_STOPPED = 2'd0;
  localparam logic [1:0] STRM_RUNNING = 2'd1;
  localparam logic [1:0] STRM_PAUSED  = 2'd2;

  // status codes
  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_SHUT_DOWN   = 3'd1;
  localparam logic [2:0] STAT_INVALID_REQ = 3'd2;
  localparam logic [2:0] STAT_WRONG_STATE = 3'd3;
  localparam logic [2:0] STAT_INVALID_TRN = 3'd4;

  // event kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_STARTED = 3'd1;
  localparam logic [2:0] KIND_STOPPED = 3'd2;
  localparam logic [2:0] KIND_SAMPLE  = 3'd3;
  localparam logic [2:0] KIND_TICK    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_EPOCH_TICK = 2'd0;
  localparam logic [1:0] CFG_EPOCH_TIME = 2'd1;
  localparam logic [1:0] CFG_TICK_RATE  = 2'd2;
  localparam logic [1:0] CFG_FRAME_DUR  = 2'd3;

  typedef struct packed {
    logic        start;
    logic [63:0] tick;
  } conv_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] event_time;
  } conv_rsp_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         event_kind;
    logic [15:0]        served_token;
    logic               served_token_present;
    logic signed [63:0] event_time;
    logic               oldest_dropped;
    logic [1:0]         released_count;
    logic               time_forced;
    logic [1:0]         pending_count;
    logic [1:0]         current_state;
  } result_t;

endpackage

// ===== hw/rtl/frtc_in_if.sv =====
// frtc_in_if: event channel of the frame request timestamp controller
// valid/ready handshake with the event word; no dependencies

interface frtc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [1:0]  target_state;
  logic [15:0] token;
  logic        token_present;
  logic [63:0] tick_count;

  modport source (
    output valid, mode, target_state, token, token_present, tick_count,
    input  ready
  );
  modport sink (
    input  valid, mode, target_state, token, token_present, tick_count,
    output ready
  );
endinterface

// ===== hw/rtl/frtc_out_if.sv =====
// frtc_out_if: result channel of the frame request timestamp controller
// valid/ready handshake with the result word; no dependencies

interface frtc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [2:0]         event_kind;
  logic [15:0]        served_token;
  logic               served_token_present;
  logic signed [63:0] event_time;
  logic               oldest_dropped;
  logic [1:0]         released_count;
  logic               time_forced;
  logic [1:0]         pending_count;
  logic [1:0]         current_state;

  modport source (
    output valid, status, event_kind, served_token, served_token_present, event_time,
    output oldest_dropped, released_count, time_forced, pending_count, current_state,
    input  ready
  );
  modport sink (
    input  valid, status, event_kind, served_token, served_token_present, event_time,
    input  oldest_dropped, released_count, time_forced, pending_count, current_state,
    output ready
  );
endinterface

// ===== hw/rtl/frtc_conv.sv =====
// frtc_conv: iterative tick to 100 ns time converter built around one shared 65-bit adder
// depends on frtc_pkg

module frtc_conv (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  frtc_pkg::conv_req_t    req_i,
  input  logic [63:0]            epoch_tick_i,
  input  logic signed [63:0]     epoch_time_i,
  input  logic [40:0]            tick_rate_i,
  output frtc_pkg::conv_rsp_t    rsp_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_DIV1 = 3'd1;
  localparam logic [2:0] PH_MUL1 = 3'd2;
  localparam logic [2:0] PH_BASE = 3'd3;
  localparam logic [2:0] PH_MUL2 = 3'd4;
  localparam logic [2:0] PH_DIV2 = 3'd5;
  localparam logic [2:0] PH_FIN  = 3'd6;

  localparam logic [6:0] DIV_LAST = 7'(frtc_pkg::DIV_STEPS - 1);
  localparam logic [6:0] MUL_LAST = 7'(frtc_pkg::HNS_W - 1);
  localparam logic [4:0] MSB_IDX  = 5'(frtc_pkg::HNS_W - 1);

  logic [2:0]         phase_q, phase_d;
  logic [6:0]         cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [64:0]        acc_q, acc_d;
  logic [64:0]        quo_q, quo_d;
  logic [40:0]        rem_q, rem_d;
  logic [63:0]        base_q, base_d;
  logic signed [63:0] time_q, time_d;

  logic [64:0] op_a, op_b;
  logic        op_sub;
  logic [65:0] sum;
  logic        carry;
  logic        mul_bit;

  // constant bits walked msb first
  assign mul_bit = frtc_pkg::HNS_PER_SEC[MSB_IDX - cnt_q[4:0]];

  // operand select for the shared adder
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        op_a   = {1'b0, req_i.tick};
        op_b   = {1'b0, epoch_tick_i};
        op_sub = 1'b1;
      end
      PH_DIV1, PH_DIV2: begin
        op_a   = {23'b0, rem_q, quo_q[64]};
        op_b   = {24'b0, tick_rate_i};
        op_sub = 1'b1;
      end
      PH_MUL1: begin
        op_a = {acc_q[63:0], 1'b0};
        op_b = mul_bit ? {1'b0, quo_q[63:0]} : 65'b0;
      end
      PH_BASE: begin
        op_a = {1'b0, acc_q[63:0]};
        op_b = {1'b0, epoch_time_i};
      end
      PH_MUL2: begin
        op_a = {acc_q[63:0], 1'b0};
        op_b = mul_bit ? {24'b0, rem_q} : 65'b0;
      end
      PH_FIN: begin
        op_a = {1'b0, base_q};
        op_b = quo_q;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign sum   = {1'b0, op_a} + {1'b0, op_b ^ {65{op_sub}}} + {65'b0, op_sub};
  assign carry = sum[65];

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    base_d  = base_q;
    time_d  = time_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          if (tick_rate_i == 41'b0) begin
            base_d  = epoch_time_i;
            quo_d   = '0;
            phase_d = PH_FIN;
          end else begin
            // no borrow means tick >= epoch; equal gives zero anyway
            quo_d   = {1'b0, carry ? sum[63:0] : 64'b0};
            rem_d   = '0;
            cnt_d   = '0;
            phase_d = PH_DIV1;
          end
        end
      end
      PH_DIV1, PH_DIV2: begin
        rem_d = carry ? sum[40:0] : op_a[40:0];
        quo_d = {quo_q[63:0], carry};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == DIV_LAST) begin
          cnt_d = '0;
          if (phase_q == PH_DIV1) begin
            acc_d   = '0;
            phase_d = PH_MUL1;
          end else begin
            phase_d = PH_FIN;
          end
        end
      end
      PH_MUL1: begin
        acc_d = sum[64:0];
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          phase_d = PH_BASE;
        end
      end
      PH_BASE: begin
        base_d  = sum[63:0];
        acc_d   = '0;
        cnt_d   = '0;
        phase_d = PH_MUL2;
      end
      PH_MUL2: begin
        acc_d = sum[64:0];
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == MUL_LAST) begin
          // remainder times 10^7 becomes the second dividend
          quo_d   = sum[64:0];
          rem_d   = '0;
          cnt_d   = '0;
          phase_d = PH_DIV2;
        end
      end
      PH_FIN: begin
        time_d  = $signed(sum[63:0]);
        done_d  = 1'b1;
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    time_q <= time_d;
  end

  assign rsp_o.done       = done_q;
  assign rsp_o.event_time = time_q;

endmodule

// ===== hw/rtl/frame_request_timestamp_controller_top.sv =====
// Capture stream controller: stream state, shutdown flag, sample request fifo and sample
// timestamps. Events that need no time (set state, start, stop, shutdown, request, and a frame
// ready or tick that does nothing) pass from accept through the EXEC and EMIT states. A
// delivered frame ready or a tick while running also waits in CONV while the tick is converted
// to 100 ns time in frtc_conv, whose single 65-bit adder runs two 65-step divisions by the
// tick rate and two 24-step multiplies by 10^7; a zero tick rate skips them. One event is in
// work at a time; a finished result waits in the output register while the next word is taken.
// Depends on frtc_pkg, frtc_in_if, frtc_out_if and frtc_conv.

module frame_request_timestamp_controller_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  frtc_in_if.sink     in_i,
  frtc_out_if.source  out_o
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_CONV = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  // configuration
  logic [63:0]        epoch_tick_q;
  logic signed [63:0] epoch_time_q;
  logic [40:0]        tick_rate_q;
  logic [31:0]        frame_dur_q;

  // event word held during work
  logic [2:0]  mode_q;
  logic [1:0]  target_q;
  logic [15:0] token_q;
  logic        present_q;
  logic [63:0] tick_q;

  logic [1:0]         state_q, state_d;
  logic [1:0]         stream_q, stream_d;
  logic               shut_q, shut_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic signed [63:0] last_q, last_d;
  logic [16:0]        store_q [QUEUE_DEPTH];

  frtc_pkg::result_t res_q, res_d, out_q;
  logic              out_valid_q;

  frtc_pkg::conv_req_t conv_req;
  frtc_pkg::conv_rsp_t conv_rsp;
  logic                conv_start;

  logic               accept;
  logic               emit_fire;
  logic               full;
  logic [IDX_W-1:0]   head_inc;
  logic [IDX_W:0]     tail_sum, tail_wrap;
  logic [IDX_W-1:0]   tail_idx;
  logic [16:0]        head_entry;
  logic               push_we;
  logic [CNT_W+1:0]   rel_ext, pend_ext;
  logic               force_time;
  logic signed [63:0] forced_t;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign emit_fire  = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  // fifo pointers
  assign full      = (count_q == DEPTH_C);
  assign head_inc  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign tail_sum  = {1'b0, head_q} + {1'b0, count_q[IDX_W-1:0]};
  assign tail_wrap = (tail_sum >= DEPTH_X) ? tail_sum - DEPTH_X : tail_sum;
  // full queue overwrites the oldest slot
  assign tail_idx   = full ? head_q : tail_wrap[IDX_W-1:0];
  assign head_entry = store_q[head_q];
  assign rel_ext    = {2'b0, count_q};

  // monotonic forcing against the previous sample time
  assign force_time = !last_q[63] && (conv_rsp.event_time <= last_q);
  assign forced_t   = last_q + $signed({32'b0, frame_dur_q});

  assign conv_req.start = conv_start;
  assign conv_req.tick  = tick_q;

  frtc_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (conv_req),
    .epoch_tick_i (epoch_tick_q),
    .epoch_time_i (epoch_time_q),
    .tick_rate_i  (tick_rate_q),
    .rsp_o        (conv_rsp)
  );

  always_comb begin
    state_d    = state_q;
    stream_d   = stream_q;
    shut_d     = shut_q;
    head_d     = head_q;
    count_d    = count_q;
    last_d     = last_q;
    res_d      = res_q;
    push_we    = 1'b0;
    conv_start = 1'b0;
    pend_ext   = {2'b0, count_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d            = '0;
        res_d.status     = frtc_pkg::STAT_OK;
        res_d.event_kind = frtc_pkg::KIND_NONE;
        unique case (mode_q)
          frtc_pkg::MODE_SET_STATE: begin
            if (shut_q) begin
              res_d.status = frtc_pkg::STAT_SHUT_DOWN;
            end else begin
              unique case (target_q)
                frtc_pkg::STRM_RUNNING: stream_d = frtc_pkg::STRM_RUNNING;
                frtc_pkg::STRM_STOPPED: stream_d = frtc_pkg::STRM_STOPPED;
                frtc_pkg::STRM_PAUSED: begin
                  if (stream_q == frtc_pkg::STRM_RUNNING ||
                      stream_q == frtc_pkg::STRM_PAUSED) begin
                    stream_d = frtc_pkg::STRM_PAUSED;
                  end else begin
                    res_d.status = frtc_pkg::STAT_INVALID_TRN;
                  end
                end
                default: res_d.status = frtc_pkg::STAT_INVALID_REQ;
              endcase
            end
          end
          frtc_pkg::MODE_START: begin
            if (shut_q) begin
              res_d.status = frtc_pkg::STAT_SHUT_DOWN;
            end else begin
              stream_d         = frtc_pkg::STRM_RUNNING;
              last_d           = '1;
              res_d.event_kind = frtc_pkg::KIND_STARTED;
            end
          end
          frtc_pkg::MODE_STOP: begin
            if (shut_q) begin
              res_d.status = frtc_pkg::STAT_SHUT_DOWN;
            end else begin
              stream_d         = frtc_pkg::STRM_STOPPED;
              res_d.event_kind = frtc_pkg::KIND_STOPPED;
            end
            res_d.released_count = rel_ext[1:0];
            count_d              = '0;
            head_d               = '0;
          end
          frtc_pkg::MODE_SHUTDOWN: begin
            shut_d               = 1'b1;
            stream_d             = frtc_pkg::STRM_STOPPED;
            res_d.released_count = rel_ext[1:0];
            count_d              = '0;
            head_d               = '0;
          end
          frtc_pkg::MODE_REQUEST: begin
            priority if (shut_q) begin
              res_d.status = frtc_pkg::STAT_SHUT_DOWN;
            end else if (stream_q == frtc_pkg::STRM_PAUSED) begin
              res_d.status = frtc_pkg::STAT_INVALID_REQ;
            end else if (stream_q != frtc_pkg::STRM_RUNNING) begin
              res_d.status = frtc_pkg::STAT_WRONG_STATE;
            end else begin
              push_we = 1'b1;
              if (full) begin
                head_d               = head_inc;
                res_d.oldest_dropped = 1'b1;
              end else begin
                count_d = count_q + 1'b1;
              end
            end
          end
          frtc_pkg::MODE_FRAME: begin
            if (!shut_q && stream_q == frtc_pkg::STRM_RUNNING && count_q != '0) begin
              head_d                     = head_inc;
              count_d                    = count_q - 1'b1;
              res_d.served_token         = head_entry[15:0];
              res_d.served_token_present = head_entry[16];
              res_d.event_kind           = frtc_pkg::KIND_SAMPLE;
              conv_start                 = 1'b1;
            end
          end
          frtc_pkg::MODE_TICK: begin
            if (!shut_q && stream_q == frtc_pkg::STRM_RUNNING) begin
              res_d.event_kind = frtc_pkg::KIND_TICK;
              conv_start       = 1'b1;
            end
          end
          default: begin
            res_d.status = frtc_pkg::STAT_OK;
          end
        endcase
        pend_ext            = {2'b0, count_d};
        res_d.pending_count = pend_ext[1:0];
        res_d.current_state = stream_d;
        state_d             = conv_start ? S_CONV : S_EMIT;
      end
      S_CONV: begin
        if (conv_rsp.done) begin
          if (mode_q == frtc_pkg::MODE_FRAME) begin
            res_d.event_time  = force_time ? forced_t : conv_rsp.event_time;
            res_d.time_forced = force_time;
            last_d            = force_time ? forced_t : conv_rsp.event_time;
          end else begin
            res_d.event_time = conv_rsp.event_time;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      stream_q     <= frtc_pkg::STRM_STOPPED;
      shut_q       <= 1'b0;
      head_q       <= '0;
      count_q      <= '0;
      last_q       <= '1;
      out_valid_q  <= 1'b0;
      epoch_tick_q <= '0;
      epoch_time_q <= '0;
      tick_rate_q  <= 41'd10000000;
      frame_dur_q  <= 32'd333333;
    end else begin
      state_q  <= state_d;
      stream_q <= stream_d;
      shut_q   <= shut_d;
      head_q   <= head_d;
      count_q  <= count_d;
      last_q   <= last_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          frtc_pkg::CFG_EPOCH_TICK: epoch_tick_q <= cfg_wdata_i;
          frtc_pkg::CFG_EPOCH_TIME: epoch_time_q <= $signed(cfg_wdata_i);
          frtc_pkg::CFG_TICK_RATE:  tick_rate_q  <= cfg_wdata_i[40:0];
          frtc_pkg::CFG_FRAME_DUR:  frame_dur_q  <= cfg_wdata_i[31:0];
          default:                  epoch_tick_q <= epoch_tick_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= in_i.mode;
      target_q  <= in_i.target_state;
      token_q   <= in_i.token;
      present_q <= in_i.token_present;
      tick_q    <= in_i.tick_count;
    end
    if (push_we) begin
      store_q[tail_idx] <= {present_q, token_q};
    end
    res_q <= res_d;
    if (emit_fire) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.status               = out_q.status;
  assign out_o.event_kind           = out_q.event_kind;
  assign out_o.served_token         = out_q.served_token;
  assign out_o.served_token_present = out_q.served_token_present;
  assign out_o.event_time           = out_q.event_time;
  assign out_o.oldest_dropped       = out_q.oldest_dropped;
  assign out_o.released_count       = out_q.released_count;
  assign out_o.time_forced          = out_q.time_forced;
  assign out_o.pending_count        = out_q.pending_count;
  assign out_o.current_state        = out_q.current_state;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("request fifo count above depth");

  a_shut_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shut_q |=> shut_q)
    else $error("shutdown flag cleared");

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_rsp.done |-> state_q == S_CONV)
    else $error("converter finished outside a conversion wait");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_start |=> !conv_rsp.done)
    else $error("converter answered in the cycle after start");
`endif

endmodule
